@@ rtl/core/tcsd_pkg.sv @@
// Shared types, constants and helpers for the text cell stream decoder.
package tcsd_pkg;

	// Header length and fixed register properties
	localparam int unsigned HEADER_LEN = 9;
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned LINE_COLUMNS_W = 13;
	localparam logic [LINE_COLUMNS_W-1:0] LINE_COLUMNS_RESET = 13'd80;
	localparam logic [LINE_COLUMNS_W-1:0] LINE_COLUMNS_MAX = 13'd4096;
	localparam int unsigned PADDR_W = 3;

	// Command codes (low three bits kept while a command is pending)
	localparam logic [2:0] CMD_NONE = 3'd0;
	localparam logic [2:0] CMD_POS  = 3'd1;
	localparam logic [2:0] CMD_FORE = 3'd2;
	localparam logic [2:0] CMD_BACK = 3'd4;
	localparam logic [2:0] CMD_BOTH = 3'd6;

	// Operand byte counts at which each command completes
	localparam logic [3:0] POS_OPND_LEN  = 4'd8;
	localparam logic [3:0] COLOR_OPND_LEN = 4'd5;
	localparam logic [3:0] BOTH_OPND_LEN = 4'd9;

	// End-of-stream status codes
	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_BAD_HDR   = 2'd1;
	localparam logic [1:0] STATUS_TRUNCATED = 2'd2;

	// Register addresses
	localparam logic [0:0] REG_LINE_COLUMNS = 1'b0;

	// Work item passed from the front to the back through the queue
	typedef struct packed {
		logic        fin;
		logic [1:0]  status;
		logic        wrap;
		logic        set_pos;
		logic        set_fore;
		logic        fore_hi;
		logic        set_back;
		logic        draw;
		logic [7:0]  glyph;
		logic [63:0] opnd;
	} tcsd_op_t;

	// Expected header byte at a given position
	function automatic logic [7:0] header_byte(input logic [3:0] idx);
		logic [7:0] val;
		case (idx)
			4'd0:    val = 8'd24;
			4'd1:    val = 8'h54; // T
			4'd2:    val = 8'h55; // U
			4'd3:    val = 8'h4E; // N
			4'd4:    val = 8'h44; // D
			4'd5:    val = 8'h52; // R
			4'd6:    val = 8'h41; // A
			4'd7:    val = 8'h32; // 2
			4'd8:    val = 8'h34; // 4
			default: val = 8'h00;
		endcase
		return val;
	endfunction

	// True for a byte that opens a command
	function automatic logic is_command(input logic [7:0] b);
		return (b == {5'd0, CMD_POS}) || (b == {5'd0, CMD_FORE}) ||
			(b == {5'd0, CMD_BACK}) || (b == {5'd0, CMD_BOTH});
	endfunction

endpackage

@@ rtl/core/text_cell_stream_decoder.sv @@
// Top level of the text cell stream decoder: register port and the three parts.
// Takes one file byte per clock while the queue has room. Each byte is parsed in
// the front end in the cycle it is accepted; a byte that draws a cell, completes
// a command or ends the file is passed through a two-entry queue to the back end,
// which owns the cursor and colours and loads the output register from the queue
// head. Header and operand bytes that complete nothing produce no result and
// leave the back end untouched.
// line_columns sits at byte address 0 of the register port and may be written
// only while no transaction is in flight.
module text_cell_stream_decoder (
	input  logic                             clk,
	input  logic                             arst_n,
	// byte input
	input  logic                             data_valid,
	output logic                             data_ready,
	input  logic [7:0]                       data_byte,
	input  logic                             final_byte,
	// result output
	output logic                             result_valid,
	input  logic                             result_ready,
	output logic                             cell_valid,
	output logic [7:0]                       glyph,
	output logic [31:0]                      cell_column,
	output logic [31:0]                      cell_row,
	output logic [23:0]                      fore_rgb,
	output logic [23:0]                      back_rgb,
	output logic                             stream_end,
	output logic [1:0]                       status,
	// register port
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [tcsd_pkg::PADDR_W-1:0]     paddr,
	input  logic [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready
);
	import tcsd_pkg::*;

	logic [LINE_COLUMNS_W-1:0] line_columns_q;
	logic                      push_valid, push_ready;
	tcsd_op_t                  push_op;
	logic                      pop_valid, pop_ready;
	tcsd_op_t                  pop_op;
	logic                      reg_sel;

	// Register port
	assign pready  = 1'b1;
	assign reg_sel = (paddr[PADDR_W-1] == REG_LINE_COLUMNS);
	assign prdata  = reg_sel ? {{(32-LINE_COLUMNS_W){1'b0}}, line_columns_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_columns_q <= LINE_COLUMNS_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			line_columns_q <= pwdata[LINE_COLUMNS_W-1:0];
		end
	end

	tcsd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.data_byte  (data_byte),
		.final_byte (final_byte),
		.data_valid (data_valid),
		.data_ready (data_ready),
		.push_valid (push_valid),
		.push_op    (push_op),
		.push_ready (push_ready)
	);

	tcsd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_op    (push_op),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_op     (pop_op),
		.pop_ready  (pop_ready)
	);

	tcsd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.line_columns (line_columns_q),
		.pop_valid    (pop_valid),
		.pop_op       (pop_op),
		.pop_ready    (pop_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.cell_valid   (cell_valid),
		.glyph        (glyph),
		.cell_column  (cell_column),
		.cell_row     (cell_row),
		.fore_rgb     (fore_rgb),
		.back_rgb     (back_rgb),
		.stream_end   (stream_end),
		.status       (status)
	);

endmodule

@@ rtl/core/tcsd_front.sv @@
// Front end: header check, command parsing and operand collection.
module tcsd_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [7:0]     data_byte,
	input  logic           final_byte,
	input  logic           data_valid,
	output logic           data_ready,
	output logic           push_valid,
	output tcsd_pkg::tcsd_op_t push_op,
	input  logic           push_ready
);
	import tcsd_pkg::*;

	logic [3:0]  hdr_idx_q, hdr_idx_n;
	logic        hdr_bad_q, hdr_bad_n;
	logic [2:0]  pend_q, pend_n;
	logic [3:0]  cnt_q, cnt_n;
	logic [63:0] shift_q, shift_n;
	logic [7:0]  held_q, held_n;
	tcsd_op_t    op;
	logic        accept;
	logic        has_op;

	// Classify the incoming byte and build the work item
	always_comb begin
		hdr_idx_n = hdr_idx_q;
		hdr_bad_n = hdr_bad_q;
		pend_n    = pend_q;
		cnt_n     = cnt_q;
		shift_n   = shift_q;
		held_n    = held_q;
		op        = '0;
		if (hdr_idx_q < 4'(HEADER_LEN)) begin
			if (data_byte != header_byte(hdr_idx_q)) begin
				hdr_bad_n = 1'b1;
			end
			hdr_idx_n = hdr_idx_q + 4'd1;
		end else if (!hdr_bad_q) begin
			if (pend_q == CMD_NONE) begin
				if (is_command(data_byte)) begin
					pend_n  = data_byte[2:0];
					cnt_n   = 4'd0;
					shift_n = '0;
				end else begin
					op.wrap  = 1'b1;
					op.draw  = 1'b1;
					op.glyph = data_byte;
				end
			end else begin
				cnt_n = cnt_q + 4'd1;
				if (cnt_q == 4'd0 && pend_q != CMD_POS) begin
					held_n = data_byte;
				end else begin
					shift_n = {shift_q[55:0], data_byte};
				end
				// Completion of each command; the column wrap check of a colour
				// command byte is carried by the completing transaction
				case (pend_q)
					CMD_POS: begin
						if (cnt_n >= POS_OPND_LEN) begin
							op.set_pos = 1'b1;
							op.opnd    = shift_n;
							pend_n     = CMD_NONE;
						end
					end
					CMD_FORE, CMD_BACK: begin
						if (cnt_n >= COLOR_OPND_LEN) begin
							op.wrap     = 1'b1;
							op.set_fore = (pend_q == CMD_FORE);
							op.set_back = (pend_q == CMD_BACK);
							op.opnd     = shift_n;
							op.draw     = !is_command(held_n);
							op.glyph    = held_n;
							pend_n      = CMD_NONE;
						end
					end
					CMD_BOTH: begin
						if (cnt_n >= BOTH_OPND_LEN) begin
							op.wrap     = 1'b1;
							op.set_fore = 1'b1;
							op.fore_hi  = 1'b1;
							op.set_back = 1'b1;
							op.opnd     = shift_n;
							op.draw     = !is_command(held_n);
							op.glyph    = held_n;
							pend_n      = CMD_NONE;
						end
					end
					default: pend_n = CMD_NONE;
				endcase
			end
		end
		// End-of-stream status, header faults first
		op.fin = final_byte;
		if (final_byte) begin
			if (hdr_idx_n < 4'(HEADER_LEN) || hdr_bad_n) begin
				op.status = STATUS_BAD_HDR;
			end else if (pend_n != CMD_NONE) begin
				op.status = STATUS_TRUNCATED;
			end else begin
				op.status = STATUS_OK;
			end
		end
	end

	assign data_ready = push_ready;
	assign accept     = data_valid && data_ready;
	assign has_op     = op.draw || op.set_pos || op.set_fore || op.set_back || op.fin;
	assign push_valid = accept && has_op;
	assign push_op    = op;

	// Parser state; the final byte returns it to reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_idx_q <= '0;
			hdr_bad_q <= 1'b0;
			pend_q    <= CMD_NONE;
			cnt_q     <= '0;
			shift_q   <= '0;
			held_q    <= '0;
		end else if (accept) begin
			if (final_byte) begin
				hdr_idx_q <= '0;
				hdr_bad_q <= 1'b0;
				pend_q    <= CMD_NONE;
				cnt_q     <= '0;
				shift_q   <= '0;
				held_q    <= '0;
			end else begin
				hdr_idx_q <= hdr_idx_n;
				hdr_bad_q <= hdr_bad_n;
				pend_q    <= pend_n;
				cnt_q     <= cnt_n;
				shift_q   <= shift_n;
				held_q    <= held_n;
			end
		end
	end

endmodule

@@ rtl/core/tcsd_queue.sv @@
// Short queue of work items between the front and the back.
module tcsd_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_valid,
	input  tcsd_pkg::tcsd_op_t push_op,
	output logic               push_ready,
	output logic               pop_valid,
	output tcsd_pkg::tcsd_op_t pop_op,
	input  logic               pop_ready
);
	import tcsd_pkg::*;

	localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	tcsd_op_t             entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]     wr_ptr_q;
	logic [PTR_W-1:0]     rd_ptr_q;
	logic [CNT_W-1:0]     count_q;
	logic                 do_push;
	logic                 do_pop;

	assign push_ready = (count_q != CNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_op     = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_op;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/core/tcsd_back.sv @@
// Back end: cursor and colour state, cell emission and result register.
module tcsd_back (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic [tcsd_pkg::LINE_COLUMNS_W-1:0]   line_columns,
	input  logic                                  pop_valid,
	input  tcsd_pkg::tcsd_op_t                    pop_op,
	output logic                                  pop_ready,
	output logic                                  result_valid,
	input  logic                                  result_ready,
	output logic                                  cell_valid,
	output logic [7:0]                            glyph,
	output logic [31:0]                           cell_column,
	output logic [31:0]                           cell_row,
	output logic [23:0]                           fore_rgb,
	output logic [23:0]                           back_rgb,
	output logic                                  stream_end,
	output logic [1:0]                            status
);
	import tcsd_pkg::*;

	logic [31:0] col_q, row_q;
	logic [23:0] fore_q, back_q;
	logic [LINE_COLUMNS_W-1:0] width;
	logic        wrap_hit;
	logic [31:0] col_w, row_w;
	logic [31:0] col_n, row_n;
	logic [23:0] fore_n, back_n;
	logic        emit;
	logic        take;

	// Effective line width
	always_comb begin
		if (line_columns == '0) begin
			width = LINE_COLUMNS_RESET;
		end else if (line_columns > LINE_COLUMNS_MAX) begin
			width = LINE_COLUMNS_MAX;
		end else begin
			width = line_columns;
		end
	end

	// Wrap, then position/colour update, then draw
	always_comb begin
		wrap_hit = pop_op.wrap && (col_q == {{(32-LINE_COLUMNS_W){1'b0}}, width});
		col_w    = wrap_hit ? 32'd0 : col_q;
		row_w    = wrap_hit ? row_q + 32'd1 : row_q;
		col_n    = col_w;
		row_n    = row_w;
		if (pop_op.set_pos) begin
			row_n = pop_op.opnd[63:32];
			col_n = pop_op.opnd[31:0];
		end else if (pop_op.draw) begin
			col_n = col_w + 32'd1;
		end
		fore_n = fore_q;
		back_n = back_q;
		if (pop_op.set_fore) begin
			fore_n = pop_op.fore_hi ? pop_op.opnd[55:32] : pop_op.opnd[23:0];
		end
		if (pop_op.set_back) begin
			back_n = pop_op.opnd[23:0];
		end
	end

	assign emit      = pop_op.draw || pop_op.fin;
	assign pop_ready = !result_valid || result_ready;
	assign take      = pop_valid && pop_ready;

	// Cursor and colours; end of stream returns them to reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			fore_q <= '0;
			back_q <= '0;
		end else if (take) begin
			if (pop_op.fin) begin
				col_q  <= '0;
				row_q  <= '0;
				fore_q <= '0;
				back_q <= '0;
			end else begin
				col_q  <= col_n;
				row_q  <= row_n;
				fore_q <= fore_n;
				back_q <= back_n;
			end
		end
	end

	// Result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (take && emit) begin
			result_valid <= 1'b1;
		end else if (result_ready) begin
			result_valid <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (take && emit) begin
			cell_valid  <= pop_op.draw;
			glyph       <= pop_op.draw ? pop_op.glyph : 8'd0;
			cell_column <= pop_op.draw ? col_w : 32'd0;
			cell_row    <= pop_op.draw ? row_w : 32'd0;
			fore_rgb    <= fore_n;
			back_rgb    <= back_n;
			stream_end  <= pop_op.fin;
			status      <= pop_op.status;
		end
	end

endmodule

@@ verif/text_cell_stream_decoder_test.sv @@
// Self-checking testbench for the text cell stream decoder: random files, line widths, flow control.
module text_cell_stream_decoder_test;
	import tcsd_pkg::*;

	// Header bytes: version 24, then the text TUNDRA24
	localparam logic [71:0] FILE_TAG = {8'd24, "TUNDRA24"};
	localparam int QUIET_LIMIT = 4000;
	localparam int PHASE_BYTES = 170;
	localparam int NUM_PHASES = 10;

	// One file byte as offered on the input channel
	typedef struct packed {
		logic [7:0] data;
		logic       fin;
	} file_byte_t;

	// One result transaction as the decoder should emit it
	typedef struct packed {
		logic        drawn;
		logic [7:0]  glyph;
		logic [31:0] col;
		logic [31:0] row;
		logic [23:0] fg;
		logic [23:0] bg;
		logic        last;
		logic [1:0]  st;
	} cell_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic data_valid = 1'b0;
	logic data_ready;
	logic [7:0] data_byte = 8'd0;
	logic final_byte = 1'b0;
	logic result_valid;
	logic result_ready = 1'b0;
	logic cell_valid;
	logic [7:0] glyph;
	logic [31:0] cell_column;
	logic [31:0] cell_row;
	logic [23:0] fore_rgb;
	logic [23:0] back_rgb;
	logic stream_end;
	logic [1:0] status;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = 32'd0;
	logic [31:0] prdata;
	logic pready;

	text_cell_stream_decoder DUT (
		.clk(clk),
		.arst_n(arst_n),
		.data_valid(data_valid),
		.data_ready(data_ready),
		.data_byte(data_byte),
		.final_byte(final_byte),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.cell_valid(cell_valid),
		.glyph(glyph),
		.cell_column(cell_column),
		.cell_row(cell_row),
		.fore_rgb(fore_rgb),
		.back_rgb(back_rgb),
		.stream_end(stream_end),
		.status(status),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #10 clk = ~clk;

	// Parser state mirrored in the testbench
	logic [12:0] cols_reg = LINE_COLUMNS_RESET;
	logic [3:0]  hdr_pos = '0;
	logic        hdr_bad = 1'b0;
	logic [2:0]  cmd_open = CMD_NONE;
	logic [3:0]  opnd_cnt = '0;
	logic [63:0] opnd_acc = '0;
	logic [7:0]  cmd_glyph = '0;
	logic [23:0] cur_fg = '0;
	logic [23:0] cur_bg = '0;
	logic [31:0] cur_col = '0;
	logic [31:0] cur_row = '0;

	file_byte_t   byte_feed[$];
	cell_result_t cells_due[$];
	logic [7:0]   file_buf[$];
	file_byte_t   next_byte;

	int  mismatches = 0;
	int  results_seen = 0;
	int  bytes_planned = 0;
	int  tx_gap = 0;
	int  rx_gap = 0;
	int  squeeze = 0;
	bit  squeeze_done = 1'b0;
	bit  calm = 1'b0;
	bit  tx_jitter = 1'b1;
	bit  rx_jitter = 1'b1;
	int  cycle_cnt = 0;
	int  quiet = 0;

	function automatic logic opens_command(input logic [7:0] b);
		return b[7:3] == 5'd0 && b[2:0] inside {CMD_POS, CMD_FORE, CMD_BACK, CMD_BOTH};
	endfunction

	// Width at which the column wraps; zero means the default, large values clamp
	function automatic logic [31:0] row_width(input logic [12:0] r);
		if (r == 13'd0)
			return 32'(LINE_COLUMNS_RESET);
		if (r > LINE_COLUMNS_MAX)
			return 32'(LINE_COLUMNS_MAX);
		return 32'(r);
	endfunction

	// Advance the mirrored parser by one byte and queue the result it causes
	function automatic void decode_byte(input logic [7:0] b, input logic fin);
		logic draw;
		cell_result_t res;
		draw = 1'b0;
		res = '0;
		if (hdr_pos < HEADER_LEN) begin
			if (b != FILE_TAG[71 - 8 * hdr_pos -: 8])
				hdr_bad = 1'b1;
			hdr_pos++;
		end else if (!hdr_bad) begin
			if (cmd_open == CMD_NONE) begin
				if (cur_col == row_width(cols_reg)) begin
					cur_col = '0;
					cur_row++;
				end
				if (opens_command(b)) begin
					cmd_open = b[2:0];
					opnd_cnt = '0;
					opnd_acc = '0;
				end else begin
					draw = 1'b1;
					res.glyph = b;
				end
			end else begin
				if (opnd_cnt == 0 && cmd_open != CMD_POS)
					cmd_glyph = b;
				else
					opnd_acc = {opnd_acc[55:0], b};
				opnd_cnt++;
				case (cmd_open)
					CMD_POS: begin
						if (opnd_cnt == POS_OPND_LEN) begin
							cur_row = opnd_acc[63:32];
							cur_col = opnd_acc[31:0];
							cmd_open = CMD_NONE;
						end
					end
					CMD_FORE, CMD_BACK: begin
						if (opnd_cnt == COLOR_OPND_LEN) begin
							if (cmd_open == CMD_FORE)
								cur_fg = opnd_acc[23:0];
							else
								cur_bg = opnd_acc[23:0];
							cmd_open = CMD_NONE;
							draw = !opens_command(cmd_glyph);
						end
					end
					default: begin
						if (opnd_cnt == BOTH_OPND_LEN) begin
							cur_fg = opnd_acc[55:32];
							cur_bg = opnd_acc[23:0];
							cmd_open = CMD_NONE;
							draw = !opens_command(cmd_glyph);
						end
					end
				endcase
				if (draw)
					res.glyph = cmd_glyph;
			end
			if (draw) begin
				res.col = cur_col;
				res.row = cur_row;
				cur_col++;
			end
		end
		if (!draw && !fin)
			return;
		res.drawn = draw;
		res.fg = cur_fg;
		res.bg = cur_bg;
		res.last = fin;
		res.st = STATUS_OK;
		if (fin) begin
			if (hdr_pos < HEADER_LEN || hdr_bad)
				res.st = STATUS_BAD_HDR;
			else if (cmd_open != CMD_NONE)
				res.st = STATUS_TRUNCATED;
			hdr_pos = '0;
			hdr_bad = 1'b0;
			cmd_open = CMD_NONE;
			opnd_cnt = '0;
			opnd_acc = '0;
			cmd_glyph = '0;
			cur_fg = '0;
			cur_bg = '0;
			cur_col = '0;
			cur_row = '0;
		end
		cells_due.push_back(res);
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endfunction

	// Idling on/off stretches for both sides
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt % 200 == 0) begin
			tx_jitter <= $urandom_range(0, 3) != 0;
			rx_jitter <= $urandom_range(0, 3) != 0;
		end
	end

	// Byte driver: predicts on each accepted transaction, then offers the next byte
	always @(posedge clk) begin
		if (arst_n) begin
			if (data_valid && data_ready)
				decode_byte(data_byte, final_byte);
			if (!data_valid || data_ready) begin
				if (tx_gap > 0) begin
					tx_gap--;
					data_valid <= 1'b0;
				end else if (byte_feed.size() > 0) begin
					next_byte = byte_feed.pop_front();
					data_valid <= 1'b1;
					data_byte <= next_byte.data;
					final_byte <= next_byte.fin;
					if (tx_jitter && !calm && $urandom_range(0, 5) == 0)
						tx_gap = $urandom_range(1, 17);
				end else begin
					data_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor and receiver flow control
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && result_ready) begin
				results_seen++;
				if (cells_due.size() == 0) begin
					$error("result with nothing expected: glyph 0x%0h end %0b", glyph, stream_end);
					mismatches++;
				end else begin
					check_field("cell_valid", 32'(cells_due[0].drawn), 32'(cell_valid));
					check_field("glyph", 32'(cells_due[0].glyph), 32'(glyph));
					check_field("cell_column", cells_due[0].col, cell_column);
					check_field("cell_row", cells_due[0].row, cell_row);
					check_field("fore_rgb", 32'(cells_due[0].fg), 32'(fore_rgb));
					check_field("back_rgb", 32'(cells_due[0].bg), 32'(back_rgb));
					check_field("stream_end", 32'(cells_due[0].last), 32'(stream_end));
					check_field("status", 32'(cells_due[0].st), 32'(status));
					void'(cells_due.pop_front());
				end
			end
			// one long hold-off while bytes keep coming, so the decoder backs up
			if (!squeeze_done && results_seen >= 150 && byte_feed.size() > 20) begin
				squeeze_done = 1'b1;
				squeeze = 250;
			end
			if (squeeze > 0) begin
				squeeze--;
				result_ready <= 1'b0;
			end else if (rx_gap > 0) begin
				rx_gap--;
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
				if (rx_jitter && !calm && $urandom_range(0, 6) == 0)
					rx_gap = $urandom_range(1, 17);
			end
		end
	end

	// Watchdog: too long without any transaction while work is outstanding
	always @(posedge clk) begin
		if (arst_n) begin
			if ((data_valid && data_ready) || (result_valid && result_ready) ||
					(byte_feed.size() == 0 && !data_valid && cells_due.size() == 0))
				quiet <= 0;
			else
				quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("[text_cell_stream_decoder] ERROR");
				$finish;
			end
		end
	end

	// Wait until every byte is taken and every result has come back
	task automatic drain();
		do
			@(negedge clk);
		while (byte_feed.size() > 0 || data_valid || cells_due.size() > 0);
	endtask

	// Register write: setup cycle, then access cycle; upper data bits are don't-care
	task automatic write_line_columns(input logic [12:0] v);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'(4 * int'(REG_LINE_COLUMNS));
		pwdata <= {19'($urandom), v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		cols_reg = v;
	endtask

	function automatic logic [7:0] any_glyph();
		logic [7:0] g;
		do
			g = 8'($urandom_range(0, 255));
		while (opens_command(g));
		return g;
	endfunction

	function automatic logic [2:0] some_command();
		case ($urandom_range(0, 3))
			0: return CMD_POS;
			1: return CMD_FORE;
			2: return CMD_BACK;
			default: return CMD_BOTH;
		endcase
	endfunction

	function automatic void add_word(input logic [31:0] w, input int nbytes);
		for (int i = nbytes - 1; i >= 0; i--)
			file_buf.push_back(w[8 * i +: 8]);
	endfunction

	// First keep bytes of the header, one of them damaged if asked
	function automatic void add_header(input bit corrupt, input int keep);
		int spot;
		logic [7:0] b;
		spot = corrupt ? $urandom_range(0, 8) : -1;
		for (int i = 0; i < keep; i++) begin
			b = FILE_TAG[71 - 8 * i -: 8];
			if (i == spot)
				b ^= 8'($urandom_range(1, 255));
			file_buf.push_back(b);
		end
	endfunction

	// Cursor move, with columns around the wrap point
	function automatic void add_position();
		logic [31:0] w;
		logic [31:0] r;
		logic [31:0] c;
		w = row_width(cols_reg);
		case ($urandom_range(0, 6))
			0: c = w - 1;
			1: c = w - 2;
			2: c = w;
			3: c = w + $urandom_range(1, 3);
			4: c = '1;
			5: c = '0;
			default: c = $urandom;
		endcase
		case ($urandom_range(0, 3))
			0: r = '1;
			1: r = '0;
			default: r = $urandom;
		endcase
		file_buf.push_back({5'd0, CMD_POS});
		add_word(r, 4);
		add_word(c, 4);
	endfunction

	function automatic void add_colour(input logic [2:0] code);
		logic [7:0] g;
		g = ($urandom_range(0, 6) == 0) ? {5'd0, some_command()} : any_glyph();
		file_buf.push_back({5'd0, code});
		file_buf.push_back(g);
		if (code != CMD_BACK) begin
			file_buf.push_back(8'($urandom_range(0, 255)));
			add_word($urandom, 3);
		end
		if (code != CMD_FORE) begin
			file_buf.push_back(8'($urandom_range(0, 255)));
			add_word($urandom, 3);
		end
	endfunction

	function automatic void add_body(input int n);
		int pick;
		repeat (n) begin
			pick = $urandom_range(0, 99);
			if (pick < 55)
				file_buf.push_back(any_glyph());
			else if (pick < 63)
				add_position();
			else if (pick < 73)
				add_colour(CMD_FORE);
			else if (pick < 83)
				add_colour(CMD_BACK);
			else if (pick < 95)
				add_colour(CMD_BOTH);
			else
				file_buf.push_back(8'($urandom_range(0, 255)));
		end
	endfunction

	// A command cut off by the end of the file
	function automatic void add_partial();
		logic [2:0] code;
		int need;
		code = some_command();
		need = (code == CMD_POS) ? int'(POS_OPND_LEN) :
			(code == CMD_BOTH) ? int'(BOTH_OPND_LEN) : int'(COLOR_OPND_LEN);
		file_buf.push_back({5'd0, code});
		repeat ($urandom_range(0, need - 1))
			file_buf.push_back(8'($urandom_range(0, 255)));
	endfunction

	// Hand the buffered file to the driver, final flag on its last byte
	function automatic void ship_file();
		for (int i = 0; i < file_buf.size(); i++) begin
			byte_feed.push_back('{data: file_buf[i], fin: (i == file_buf.size() - 1)});
			bytes_planned++;
		end
		file_buf.delete();
	endfunction

	function automatic void make_file();
		int kind;
		kind = $urandom_range(0, 99);
		if (kind < 6) begin
			repeat ($urandom_range(1, 24))
				file_buf.push_back(8'($urandom_range(0, 255)));
		end else if (kind < 10) begin
			add_header(1'b0, $urandom_range(1, 8));
		end else if (kind < 16) begin
			add_header(1'b1, HEADER_LEN);
			add_body($urandom_range(0, 12));
		end else begin
			add_header(1'b0, HEADER_LEN);
			add_body(($urandom_range(0, 9) == 0) ? $urandom_range(60, 120) :
				$urandom_range(0, 40));
			if ($urandom_range(0, 3) == 0)
				add_partial();
		end
		ship_file();
	endfunction

	// Stimulus: reset, directed files, then phases of random files per line width
	initial begin
		logic [12:0] width_plan [NUM_PHASES];
		int quota;
		width_plan = '{13'd80, 13'd1, 13'd4096, 13'd3, 13'd0, 13'd8191, 13'd7, 13'd5000,
			13'd2, 13'd80};
		width_plan[8] = 13'($urandom_range(1, 4096));
		width_plan[9] = 13'($urandom_range(1, 4096));
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// glyph 0, both colours with glyph 255, end on the last colour byte
		add_header(1'b0, HEADER_LEN);
		file_buf.push_back(8'h00);
		file_buf.push_back({5'd0, CMD_BOTH});
		file_buf.push_back(8'hFF);
		file_buf.push_back(8'hFF);
		add_word(32'hFFFFFF, 3);
		file_buf.push_back(8'h00);
		add_word(32'h000000, 3);
		ship_file();
		// header that goes wrong on its third byte and ends there
		add_header(1'b0, 2);
		file_buf.push_back("X");
		ship_file();

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			if (ph > 0) begin
				drain();
				repeat (6) @(posedge clk);
				write_line_columns(width_plan[ph]);
				@(negedge clk);
			end
			if (ph == NUM_PHASES - 1)
				calm = 1'b1;
			quota = bytes_planned + PHASE_BYTES;
			while (bytes_planned < quota)
				make_file();
		end

		drain();
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("[text_cell_stream_decoder] OK");
		else
			$display("[text_cell_stream_decoder] ERROR");
		$finish;
	end

endmodule
